// ===== hw/rtl/camera_ptz_command_sequencer_defines.svh =====
// assertion macros for the camera ptz command sequencer checker
`ifndef CAMERA_PTZ_COMMAND_SEQUENCER_DEFINES_SVH
`define CAMERA_PTZ_COMMAND_SEQUENCER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CPCS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpcs check failed");

// next-cycle implication, sampled on clk, off during reset
`define CPCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpcs check failed");

`endif

// ===== hw/rtl/cpcs_pkg.sv =====
// shared types, codes and packet table of the camera ptz command sequencer
package cpcs_pkg;

    localparam int CMD_W   = 4;
    localparam int KIND_W  = 4;
    localparam int LIMIT_W = 3;
    localparam int CNT_W   = 3;
    localparam int IDX_W   = 4;
    localparam int PKT_LEN = 14;
    localparam int KQ_DEPTH = 4;
    localparam int KQ_AW    = $clog2(KQ_DEPTH);
    localparam int KQ_CW    = $clog2(KQ_DEPTH + 1);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd3;
    localparam logic [CNT_W-1:0]   CNT_MAX     = 3'd7;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ZOOM_STOP    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_ZOOM_IN      = 4'd2;
    localparam logic [CMD_W-1:0] CMD_ZOOM_OUT     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_FOCUS_STOP   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_FOCUS_FAR    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_FOCUS_NEAR   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_FOCUS_AUTO   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_FOCUS_MANUAL = 4'd8;
    localparam logic [CMD_W-1:0] CMD_IRIS_UP      = 4'd9;
    localparam logic [CMD_W-1:0] CMD_IRIS_DOWN    = 4'd10;
    localparam logic [CMD_W-1:0] CMD_IRIS_AUTO    = 4'd12;
    localparam logic [CMD_W-1:0] CMD_IRIS_MANUAL  = 4'd13;

    // packet kinds
    localparam logic [KIND_W-1:0] K_ZOOM_STOP    = 4'd0;
    localparam logic [KIND_W-1:0] K_ZOOM_IN      = 4'd1;
    localparam logic [KIND_W-1:0] K_ZOOM_OUT     = 4'd2;
    localparam logic [KIND_W-1:0] K_FOCUS_STOP   = 4'd3;
    localparam logic [KIND_W-1:0] K_FOCUS_FAR    = 4'd4;
    localparam logic [KIND_W-1:0] K_FOCUS_NEAR   = 4'd5;
    localparam logic [KIND_W-1:0] K_FOCUS_AUTO   = 4'd6;
    localparam logic [KIND_W-1:0] K_FOCUS_MANUAL = 4'd7;
    localparam logic [KIND_W-1:0] K_IRIS_UP      = 4'd8;
    localparam logic [KIND_W-1:0] K_IRIS_DOWN    = 4'd9;
    localparam logic [KIND_W-1:0] K_IRIS_AUTO    = 4'd10;
    localparam logic [KIND_W-1:0] K_IRIS_MANUAL  = 4'd11;
    localparam logic [KIND_W-1:0] K_NONE         = 4'd12;

    localparam logic [IDX_W-1:0] IDX_LAST = 4'(PKT_LEN - 1);

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
    } kq_wr_t;

    typedef struct packed {
        logic              empty;
        logic [KIND_W-1:0] kind;
    } kq_rd_t;

    function automatic logic [7:0] pkt_byte(input logic [KIND_W-1:0] kind,
                                            input logic [IDX_W-1:0] idx);
        logic [7:0] op;
        logic [7:0] arg;
        logic [7:0] b;
        op  = 8'h00;
        arg = 8'h00;
        case (kind)
            K_ZOOM_STOP:    begin op = 8'h07; arg = 8'h00; end
            K_ZOOM_IN:      begin op = 8'h07; arg = 8'h22; end
            K_ZOOM_OUT:     begin op = 8'h07; arg = 8'h32; end
            K_FOCUS_STOP:   begin op = 8'h08; arg = 8'h00; end
            K_FOCUS_FAR:    begin op = 8'h08; arg = 8'h21; end
            K_FOCUS_NEAR:   begin op = 8'h08; arg = 8'h31; end
            K_FOCUS_AUTO:   begin op = 8'h38; arg = 8'h02; end
            K_FOCUS_MANUAL: begin op = 8'h38; arg = 8'h03; end
            K_IRIS_UP:      begin op = 8'h0b; arg = 8'h02; end
            K_IRIS_DOWN:    begin op = 8'h0b; arg = 8'h03; end
            K_IRIS_AUTO:    begin op = 8'h39; arg = 8'h00; end
            K_IRIS_MANUAL:  begin op = 8'h39; arg = 8'h03; end
            default:        begin op = 8'h00; arg = 8'h00; end
        endcase
        case (idx)
            4'd0:    b = 8'h01;
            4'd3:    b = 8'h06;
            4'd7:    b = 8'h01;
            4'd8:    b = 8'h81;
            4'd9:    b = 8'h01;
            4'd10:   b = 8'h04;
            4'd11:   b = op;
            4'd12:   b = arg;
            4'd13:   b = 8'hff;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/cpcs_front.sv =====
// front end: accepts ticks, tracks repeats and mode flags, picks the packet kind
module cpcs_front
    import cpcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [CMD_W-1:0]   command_code,
    input  logic               q_full,
    input  logic               cfg_valid,
    input  logic [LIMIT_W-1:0] cfg_data,
    output logic               cfg_ready,
    output kq_wr_t             wr
);

    logic [LIMIT_W-1:0] limit_reg;
    logic [CMD_W-1:0]   last_cmd_reg, last_cmd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               zoom_mv_reg, zoom_mv_next;
    logic               focus_mv_reg, focus_mv_next;
    logic               focus_man_reg, focus_man_next;
    logic               iris_man_reg, iris_man_next;

    logic               accept;
    logic [CNT_W-1:0]   cnt_up;
    logic               act;
    logic [KIND_W-1:0]  kind;

    assign cfg_ready = 1'b1;
    assign accept    = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            last_cmd_reg  <= '0;
            cnt_reg       <= '0;
            zoom_mv_reg   <= 1'b0;
            focus_mv_reg  <= 1'b0;
            focus_man_reg <= 1'b0;
            iris_man_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            last_cmd_reg  <= last_cmd_next;
            cnt_reg       <= cnt_next;
            zoom_mv_reg   <= zoom_mv_next;
            focus_mv_reg  <= focus_mv_next;
            focus_man_reg <= focus_man_next;
            iris_man_reg  <= iris_man_next;
        end
    end

    always_comb
    begin
        last_cmd_next  = last_cmd_reg;
        cnt_next       = cnt_reg;
        zoom_mv_next   = zoom_mv_reg;
        focus_mv_next  = focus_mv_reg;
        focus_man_next = focus_man_reg;
        iris_man_next  = iris_man_reg;
        kind           = K_NONE;

        if (command_code == last_cmd_reg)
        begin
            cnt_up = (cnt_reg == CNT_MAX) ? CNT_MAX : cnt_reg + 3'd1;
        end
        else
        begin
            cnt_up = 3'd1;
        end
        act = (cnt_up <= limit_reg) || (command_code == CMD_IRIS_UP)
            || (command_code == CMD_IRIS_DOWN);

        if (accept)
        begin
            last_cmd_next = command_code;
            cnt_next      = cnt_up;
            if (act)
            begin
                // a pending stop wins over the request
                if (zoom_mv_reg && (command_code < CMD_ZOOM_STOP
                    || command_code > CMD_ZOOM_OUT))
                begin
                    kind         = K_ZOOM_STOP;
                    zoom_mv_next = 1'b0;
                end
                else if (focus_mv_reg && (command_code < CMD_FOCUS_FAR
                    || command_code > CMD_FOCUS_MANUAL))
                begin
                    kind          = K_FOCUS_STOP;
                    focus_mv_next = 1'b0;
                end
                else
                begin
                    case (command_code)
                        CMD_ZOOM_STOP:
                        begin
                            kind         = K_ZOOM_STOP;
                            zoom_mv_next = 1'b0;
                        end
                        CMD_ZOOM_IN:
                        begin
                            kind         = K_ZOOM_IN;
                            zoom_mv_next = 1'b1;
                        end
                        CMD_ZOOM_OUT:
                        begin
                            kind         = K_ZOOM_OUT;
                            zoom_mv_next = 1'b1;
                        end
                        CMD_FOCUS_STOP:
                        begin
                            kind          = K_FOCUS_STOP;
                            focus_mv_next = 1'b0;
                        end
                        CMD_FOCUS_FAR, CMD_FOCUS_NEAR:
                        begin
                            if (!focus_man_reg)
                            begin
                                // switch to manual, retry on the next tick
                                kind           = K_FOCUS_MANUAL;
                                focus_man_next = 1'b1;
                                cnt_next       = cnt_up - 3'd1;
                            end
                            else
                            begin
                                kind = (command_code == CMD_FOCUS_FAR) ?
                                       K_FOCUS_FAR : K_FOCUS_NEAR;
                                focus_mv_next = 1'b1;
                            end
                        end
                        CMD_FOCUS_AUTO:
                        begin
                            kind           = K_FOCUS_AUTO;
                            focus_mv_next  = 1'b0;
                            focus_man_next = 1'b0;
                        end
                        CMD_FOCUS_MANUAL:
                        begin
                            kind           = K_FOCUS_MANUAL;
                            focus_man_next = 1'b1;
                        end
                        CMD_IRIS_UP, CMD_IRIS_DOWN:
                        begin
                            if (!iris_man_reg)
                            begin
                                kind          = K_IRIS_MANUAL;
                                iris_man_next = 1'b1;
                                cnt_next      = cnt_up - 3'd1;
                            end
                            else
                            begin
                                kind = (command_code == CMD_IRIS_UP) ?
                                       K_IRIS_UP : K_IRIS_DOWN;
                            end
                        end
                        CMD_IRIS_AUTO:
                        begin
                            kind          = K_IRIS_AUTO;
                            iris_man_next = 1'b0;
                        end
                        CMD_IRIS_MANUAL:
                        begin
                            kind          = K_IRIS_MANUAL;
                            iris_man_next = 1'b1;
                        end
                        default:
                        begin
                            kind = K_NONE;
                        end
                    endcase
                end
            end
        end

        wr.valid = accept && (kind != K_NONE);
        wr.kind  = kind;
    end

endmodule

// ===== hw/rtl/cpcs_kq.sv =====
// short queue of packet kinds between front and back
module cpcs_kq
    import cpcs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  kq_wr_t wr,
    input  logic   rd,
    output kq_rd_t head,
    output logic   full
);

    logic [KIND_W-1:0] mem [KQ_DEPTH];
    logic [KQ_AW-1:0]  wr_ptr_reg;
    logic [KQ_AW-1:0]  rd_ptr_reg;
    logic [KQ_CW-1:0]  cnt_reg;
    logic              do_rd;

    assign do_rd      = rd && (cnt_reg != '0);
    assign full       = (cnt_reg == KQ_CW'(KQ_DEPTH));
    assign head.empty = (cnt_reg == '0);
    assign head.kind  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr.valid)
        begin
            mem[wr_ptr_reg] <= wr.kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + KQ_AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + KQ_AW'(1);
            end
            case ({wr.valid, do_rd})
                2'b10:   cnt_reg <= cnt_reg + KQ_CW'(1);
                2'b01:   cnt_reg <= cnt_reg - KQ_CW'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ===== hw/rtl/cpcs_back.sv =====
// back end: serializes each queued kind into a 14-byte packet through an output register
module cpcs_back
    import cpcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  kq_rd_t            head,
    output logic              q_rd,
    input  logic              pop,
    output logic              empty,
    output logic [7:0]        packet_byte,
    output logic [KIND_W-1:0] packet_kind,
    output logic              last_byte
);

    logic              active_reg, active_next;
    logic [KIND_W-1:0] cur_kind_reg, cur_kind_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              ov_reg, ov_next;
    logic [7:0]        byte_reg, byte_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic              last_reg, last_next;

    logic              load;
    logic [KIND_W-1:0] emit_kind;
    logic [IDX_W-1:0]  emit_idx;
    logic              emit;

    assign empty       = !ov_reg;
    assign packet_byte = byte_reg;
    assign packet_kind = kind_reg;
    assign last_byte   = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ov_reg     <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            ov_reg     <= ov_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_kind_reg <= cur_kind_next;
        byte_reg     <= byte_next;
        kind_reg     <= kind_next;
        last_reg     <= last_next;
    end

    always_comb
    begin
        active_next   = active_reg;
        cur_kind_next = cur_kind_reg;
        idx_next      = idx_reg;
        byte_next     = byte_reg;
        kind_next     = kind_reg;
        last_next     = last_reg;
        q_rd          = 1'b0;
        emit          = 1'b0;
        emit_kind     = cur_kind_reg;
        emit_idx      = idx_reg;

        // output register free or being drained this cycle
        load = !ov_reg || pop;

        if (load)
        begin
            if (active_reg)
            begin
                emit = 1'b1;
            end
            else if (!head.empty)
            begin
                emit          = 1'b1;
                q_rd          = 1'b1;
                emit_kind     = head.kind;
                emit_idx      = '0;
                cur_kind_next = head.kind;
            end
        end

        if (emit)
        begin
            byte_next   = pkt_byte(emit_kind, emit_idx);
            kind_next   = emit_kind;
            last_next   = (emit_idx == IDX_LAST);
            active_next = (emit_idx != IDX_LAST);
            idx_next    = (emit_idx == IDX_LAST) ? '0 : emit_idx + IDX_W'(1);
        end

        ov_next = emit || (ov_reg && !pop);
    end

endmodule

// ===== hw/rtl/camera_ptz_command_sequencer.sv =====
// top level of the camera ptz command sequencer
//
//  channel   ports                                   transfer when
//  tick      push, full, command_code                push && !full
//  packet    empty, pop, packet_byte/kind, last_byte pop && !empty
//  config    cfg_valid, cfg_ready, cfg_data          cfg_valid && cfg_ready
//
//  a tick is taken whenever push is high and full low; the front end decides the packet at once
//  every decided packet gives 14 byte transfers, one per cycle while pop is held, set by the serializer
//  up to four decided packets wait in the kind queue; full is raised when it fills
//  a stall on pop holds the output register and backs up into the queue
//  reset clears the repeat count, mode flags, queue and output; repeat_limit becomes 3
module camera_ptz_command_sequencer
    import cpcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [CMD_W-1:0]   command_code,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         packet_byte,
    output logic [KIND_W-1:0]  packet_kind,
    output logic               last_byte,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    kq_wr_t kq_wr;
    kq_rd_t kq_head;
    logic   kq_rd;
    logic   kq_full;

    assign full = kq_full;

    cpcs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .command_code (command_code),
        .q_full       (kq_full),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .cfg_ready    (cfg_ready),
        .wr           (kq_wr)
    );

    cpcs_kq u_kq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (kq_wr),
        .rd    (kq_rd),
        .head  (kq_head),
        .full  (kq_full)
    );

    cpcs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (kq_head),
        .q_rd        (kq_rd),
        .pop         (pop),
        .empty       (empty),
        .packet_byte (packet_byte),
        .packet_kind (packet_kind),
        .last_byte   (last_byte)
    );

endmodule

// ===== hw/rtl/cpcs_checker.sv =====
// port-level checker for the camera ptz command sequencer, with its bind
`include "camera_ptz_command_sequencer_defines.svh"

module cpcs_checker
    import cpcs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic [7:0]         packet_byte,
    input logic [KIND_W-1:0]  packet_kind,
    input logic               last_byte,
    input logic               cfg_valid,
    input logic               cfg_ready
);

    logic [KIND_W+8:0] out_beat;

    assign out_beat = {packet_byte, packet_kind, last_byte};

    // a stalled byte holds
    `CPCS_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(out_beat))
    // bytes of one packet follow without a gap and keep their kind
    `CPCS_ASSERT_NEXT(a_pkt_cont, !empty && pop && !last_byte, !empty && $stable(packet_kind))
    // a new packet opens with the header byte
    `CPCS_ASSERT_NEXT(a_pkt_head, !empty && pop && last_byte, empty || packet_byte == 8'h01)
    // the closing byte is the terminator
    `CPCS_ASSERT_NOW(a_pkt_tail, !empty && last_byte, packet_byte == 8'hff)
    // config writes never stall
    `CPCS_ASSERT_NOW(a_cfg_rdy, cfg_valid, cfg_ready)

endmodule

bind camera_ptz_command_sequencer cpcs_checker u_cpcs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .packet_byte  (packet_byte),
    .packet_kind  (packet_kind),
    .last_byte    (last_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);

// ===== test/testbench.sv =====
// self-checking testbench of the camera ptz command sequencer with its packet predictor
module testbench;
    import cpcs_pkg::*;

    typedef struct packed {
        logic [7:0]        data;
        logic [KIND_W-1:0] kind;
        logic              last;
    } packet_beat_t;

    class ptz_scoreboard;
        localparam logic [63:0] HEADER = 64'h0100000600000001;

        logic [47:0]        payload_of [12];
        logic [LIMIT_W-1:0] limit;
        logic [CMD_W-1:0]   last_cmd;
        logic [CNT_W-1:0]   count;
        bit                 zoom_moving;
        bit                 focus_moving;
        bit                 focus_man_flag;
        bit                 iris_man_flag;
        packet_beat_t       beat_q [$];
        int                 errors;

        function new();
            payload_of = '{48'h8101040700ff, 48'h8101040722ff, 48'h8101040732ff,
                           48'h8101040800ff, 48'h8101040821ff, 48'h8101040831ff,
                           48'h8101043802ff, 48'h8101043803ff, 48'h8101040b02ff,
                           48'h8101040b03ff, 48'h8101043900ff, 48'h8101043903ff};
            limit          = LIMIT_RESET;
            last_cmd       = '0;
            count          = '0;
            zoom_moving    = 1'b0;
            focus_moving   = 1'b0;
            focus_man_flag = 1'b0;
            iris_man_flag  = 1'b0;
            errors         = 0;
        endfunction

        function void set_limit(input logic [LIMIT_W-1:0] value);
            limit = value;
        endfunction

        function int pending();
            return beat_q.size();
        endfunction

        function void queue_packet(input logic [KIND_W-1:0] k);
            packet_beat_t beat;
            for (int i = 0; i < PKT_LEN; i++) begin
                beat.data = (i < 8) ? HEADER[63 - 8 * i -: 8]
                                    : payload_of[k][47 - 8 * (i - 8) -: 8];
                beat.kind = k;
                beat.last = (i == PKT_LEN - 1);
                beat_q.push_back(beat);
            end
        endfunction

        function void note_tick(input logic [CMD_W-1:0] cmd);
            logic [KIND_W-1:0] k;
            bit                iris_step;
            iris_step = (cmd == CMD_IRIS_UP) || (cmd == CMD_IRIS_DOWN);
            if (cmd == last_cmd) begin
                if (count < CNT_MAX)
                    count++;
            end
            else begin
                count    = 3'd1;
                last_cmd = cmd;
            end
            if (!(count <= limit || iris_step))
                return;
            k = K_NONE;
            if (zoom_moving && (cmd < CMD_ZOOM_STOP || cmd > CMD_ZOOM_OUT)) begin
                k           = K_ZOOM_STOP;
                zoom_moving = 1'b0;
            end
            else if (focus_moving && (cmd < CMD_FOCUS_FAR || cmd > CMD_FOCUS_MANUAL)) begin
                k            = K_FOCUS_STOP;
                focus_moving = 1'b0;
            end
            else begin
                case (cmd)
                    CMD_ZOOM_STOP: begin k = K_ZOOM_STOP; zoom_moving = 1'b0; end
                    CMD_ZOOM_IN:   begin k = K_ZOOM_IN;   zoom_moving = 1'b1; end
                    CMD_ZOOM_OUT:  begin k = K_ZOOM_OUT;  zoom_moving = 1'b1; end
                    CMD_FOCUS_STOP: begin k = K_FOCUS_STOP; focus_moving = 1'b0; end
                    CMD_FOCUS_FAR, CMD_FOCUS_NEAR:
                    begin
                        // manual mode goes out first, the move is retried next tick
                        if (!focus_man_flag) begin
                            k              = K_FOCUS_MANUAL;
                            focus_man_flag = 1'b1;
                            if (count > 0)
                                count--;
                        end
                        else begin
                            k            = (cmd == CMD_FOCUS_FAR) ? K_FOCUS_FAR : K_FOCUS_NEAR;
                            focus_moving = 1'b1;
                        end
                    end
                    CMD_FOCUS_AUTO:
                    begin
                        k              = K_FOCUS_AUTO;
                        focus_moving   = 1'b0;
                        focus_man_flag = 1'b0;
                    end
                    CMD_FOCUS_MANUAL: begin k = K_FOCUS_MANUAL; focus_man_flag = 1'b1; end
                    CMD_IRIS_UP, CMD_IRIS_DOWN:
                    begin
                        if (!iris_man_flag) begin
                            k             = K_IRIS_MANUAL;
                            iris_man_flag = 1'b1;
                            if (count > 0)
                                count--;
                        end
                        else begin
                            k = (cmd == CMD_IRIS_UP) ? K_IRIS_UP : K_IRIS_DOWN;
                        end
                    end
                    CMD_IRIS_AUTO:   begin k = K_IRIS_AUTO;   iris_man_flag = 1'b0; end
                    CMD_IRIS_MANUAL: begin k = K_IRIS_MANUAL; iris_man_flag = 1'b1; end
                    default:         k = K_NONE;
                endcase
            end
            if (k != K_NONE)
                queue_packet(k);
        endfunction

        function void check_beat(input logic [7:0] data, input logic [KIND_W-1:0] kind,
                                 input logic last);
            packet_beat_t exp_beat;
            if (beat_q.size() == 0) begin
                $display("%0t: unexpected packet byte %h kind %0d last %b",
                         $time, data, kind, last);
                errors++;
                return;
            end
            exp_beat = beat_q.pop_front();
            if (data !== exp_beat.data) begin
                $display("%0t: packet_byte expected %h got %h", $time, exp_beat.data, data);
                errors++;
            end
            if (kind !== exp_beat.kind) begin
                $display("%0t: packet_kind expected %0d got %0d", $time, exp_beat.kind, kind);
                errors++;
            end
            if (last !== exp_beat.last) begin
                $display("%0t: last_byte expected %b got %b", $time, exp_beat.last, last);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               push         = 1'b0;
    logic               full;
    logic [CMD_W-1:0]   command_code = '0;
    logic               empty;
    logic               pop          = 1'b0;
    logic [7:0]         packet_byte;
    logic [KIND_W-1:0]  packet_kind;
    logic               last_byte;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data     = '0;
    bit                 steady       = 1'b0;

    ptz_scoreboard sb = new();

    camera_ptz_command_sequencer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command_code (command_code),
        .empty        (empty),
        .pop          (pop),
        .packet_byte  (packet_byte),
        .packet_kind  (packet_kind),
        .last_byte    (last_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // every transfer is noted at the edge that completes it
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (pop && !empty)
                sb.check_beat(packet_byte, packet_kind, last_byte);
            if (cfg_valid && cfg_ready)
                sb.set_limit(cfg_data);
            if (push && !full)
                sb.note_tick(command_code);
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_tick(input logic [CMD_W-1:0] code);
        int gap;
        push         <= 1'b1;
        command_code <= code;
        do
            @(posedge clk);
        while (full);
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end
            else begin
                pop <= 1'b1;
                if (!steady)
                    stall = idle_len();
            end
        end
    end

    initial
    begin
        logic [CMD_W-1:0]   directed [$];
        logic [LIMIT_W-1:0] limits [8];
        logic [CMD_W-1:0]   code;
        int                 sent;
        int                 run;
        directed = '{4'd0, CMD_ZOOM_IN, 4'd11, CMD_ZOOM_OUT, CMD_ZOOM_STOP,
                     CMD_FOCUS_FAR, CMD_FOCUS_FAR, CMD_FOCUS_NEAR, 4'd15, CMD_FOCUS_STOP,
                     CMD_FOCUS_AUTO, CMD_FOCUS_MANUAL, CMD_IRIS_UP, CMD_IRIS_UP,
                     CMD_IRIS_DOWN, CMD_IRIS_DOWN, CMD_IRIS_DOWN, CMD_IRIS_DOWN,
                     CMD_IRIS_AUTO, CMD_IRIS_MANUAL, CMD_ZOOM_IN, CMD_ZOOM_IN,
                     CMD_ZOOM_IN, CMD_ZOOM_IN, 4'd14};
        limits = '{3'd1, 3'd6, 3'd0, 3'd7, 3'd2, 3'd5, 3'd4, 3'd3};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_tick(directed[i]);
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            steady = (phase % 3 == 1);
            write_limit(limits[phase]);
            sent = 0;
            while (sent < 28) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise, any code
                    send_tick(4'($urandom_range(0, 15)));
                    sent++;
                end
                else begin
                    // a held command, repeated over several ticks
                    code = 4'($urandom_range(1, 13));
                    run  = $urandom_range(1, 8);
                    repeat (run)
                        send_tick(code);
                    sent += run;
                end
                if (phase == 2 && sent >= 14 && sent < 22)
                    wait_drained();
            end
            wait_drained();
        end

        steady = 1'b0;
        if (sb.errors == 0 && sb.pending() == 0)
            $display("camera_ptz_command_sequencer test passed");
        else
            $display("camera_ptz_command_sequencer test failed");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("camera_ptz_command_sequencer test failed");
        $finish;
    end

endmodule
